FILE: sv/vlmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlmr_pkg
// Shared constants, codes and types of the message ring core.
// ----------------------------------------------------------------------------
package vlmr_pkg;

   localparam int RING_DEPTH   = 1024;
   localparam int LINE_BYTES   = 64;
   localparam int HEADER_BYTES = 8;
   localparam int LINE_SHIFT   = $clog2(LINE_BYTES);

   localparam int ADDR_W  = $clog2(RING_DEPTH);  // line index
   localparam int LINES_W = ADDR_W + 1;          // line count, holds RING_DEPTH
   localparam int ENTRY_W = 49;                  // pad mark, size, id
   localparam int PAD_BIT = 48;

   typedef enum logic [1:0] {
      ACT_WRITE   = 2'd0,
      ACT_PEEK    = 2'd1,
      ACT_CONSUME = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_NO_ROOM  = 3'd1,
      STS_EMPTY    = 3'd2,
      STS_BAD_ID   = 3'd3,
      STS_BAD_SIZE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_PAD,
      FSM_ZERO
   } fsm_type;

   // configuration handed from the register block to the core
   typedef struct packed {
      logic [LINES_W-1:0] lines;   // clamped line count
      logic               clear;   // ring_lines written this cycle
   } cfg_type;

endpackage

FILE: sv/vlmr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlmr request / response channels
// Valid/ready channels carrying ring requests and their responses.
// ----------------------------------------------------------------------------
interface vlmr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] msg_id_in;
   logic [15:0] payload_bytes;

   modport source (output valid, output action, output msg_id_in,
                   output payload_bytes, input ready);
   modport sink (input valid, input action, input msg_id_in,
                 input payload_bytes, output ready);
endinterface

interface vlmr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [9:0]  line_offset;
   logic [31:0] msg_id_out;
   logic [15:0] msg_size_out;
   logic [16:0] free_bytes;

   modport source (output valid, output status, output line_offset,
                   output msg_id_out, output msg_size_out, output free_bytes,
                   input ready);
   modport sink (input valid, input status, input line_offset,
                 input msg_id_out, input msg_size_out, input free_bytes,
                 output ready);
endinterface

FILE: sv/vlmr_hdr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlmr_hdr_ram
// Header store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vlmr_hdr_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [vlmr_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [vlmr_pkg::ENTRY_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [vlmr_pkg::ADDR_W-1:0]  rd_addr,
   output logic [vlmr_pkg::ENTRY_W-1:0] rd_data
);

   logic [vlmr_pkg::ENTRY_W-1:0] mem_ff [vlmr_pkg::RING_DEPTH];
   logic [vlmr_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/vlmr_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlmr_csr
// APB register block holding ring_lines; a write also empties the ring.
// ----------------------------------------------------------------------------
module vlmr_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output vlmr_pkg::cfg_type     cfg
);

   localparam logic REG_RING_LINES = 1'b0;

   logic [vlmr_pkg::LINES_W-1:0] lines_ff;
   logic [vlmr_pkg::LINES_W-1:0] lines_in;
   logic                         wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_RING_LINES);

   always_comb begin
      lines_in = lines_ff;
      if (wr_hit) begin
         lines_in = pwdata[vlmr_pkg::LINES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff <= vlmr_pkg::LINES_W'(vlmr_pkg::RING_DEPTH);
      end else begin
         lines_ff <= lines_in;
      end
   end

   // clamp to 2..RING_DEPTH
   always_comb begin
      cfg.clear = wr_hit;
      if (lines_ff < vlmr_pkg::LINES_W'(2)) begin
         cfg.lines = vlmr_pkg::LINES_W'(2);
      end else if (lines_ff > vlmr_pkg::LINES_W'(vlmr_pkg::RING_DEPTH)) begin
         cfg.lines = vlmr_pkg::LINES_W'(vlmr_pkg::RING_DEPTH);
      end else begin
         cfg.lines = lines_ff;
      end
   end

   always_comb begin
      if (paddr[2] == REG_RING_LINES) begin
         prdata = 32'(lines_ff);
      end else begin
         prdata = '0;
      end
   end

endmodule

FILE: sv/variable_length_message_ring_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_length_message_ring_core
// Space manager for a ring of cache lines holding variable-length messages.
// ----------------------------------------------------------------------------
// Requests arrive on req_bus (valid/ready): write reserves header plus payload
// lines and returns the start line, peek reports the head message, consume
// peeks and advances past it. Every request yields exactly one response on
// rsp_bus with a status and the free bytes left. Payload data never passes
// through the block; the requester moves it.
// Headers live in a single-port-write, registered-read memory. The header
// read is issued as a request is taken; the request is then evaluated in the
// execute state and its response registered when it commits. A new request
// is not taken until that response has committed. A write that wraps
// (padding header plus header at line 0) passes through an added pad state,
// set by the single memory write port, and a peek/consume that skips padding
// through an added zero state for the second header read.
// While rsp_bus is stalled with a response held, the next request finishes
// its work but waits before committing; ready is low until it does.
// Reset empties the ring and sets ring_lines to 1024; header contents are
// not cleared. A write to ring_lines (APB, address 0) also empties the ring.
// ----------------------------------------------------------------------------
module variable_length_message_ring_core (
   input  logic        clock,
   input  logic        reset,
   vlmr_req_if.sink    req_bus,
   vlmr_rsp_if.source  rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW = vlmr_pkg::ADDR_W;
   localparam int LW = vlmr_pkg::LINES_W;
   localparam int SW = LW + 1;   // line sums up to twice the depth

   function automatic logic [SW-1:0] lines_for(input logic [15:0] pay);
      logic [16:0] sum;
      sum = 17'(pay) + 17'(vlmr_pkg::HEADER_BYTES + vlmr_pkg::LINE_BYTES - 1);
      return SW'(sum >> vlmr_pkg::LINE_SHIFT);
   endfunction

   function automatic logic [16:0] free_span(input logic [LW-1:0] n,
                                             input logic [AW-1:0] r,
                                             input logic [AW-1:0] w);
      logic [LW-1:0] span;
      if (w >= r) begin
         span = n - LW'(w);
         if (LW'(r) > span) begin
            span = LW'(r);
         end
      end else begin
         span = LW'(r) - LW'(w);
      end
      return 17'(span) << vlmr_pkg::LINE_SHIFT;
   endfunction

   vlmr_pkg::cfg_type cfg;

   vlmr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   logic                         mem_we;
   logic [AW-1:0]                mem_waddr;
   logic [vlmr_pkg::ENTRY_W-1:0] mem_wdata;
   logic                         mem_re;
   logic [AW-1:0]                mem_raddr;
   logic [vlmr_pkg::ENTRY_W-1:0] mem_rdata;

   vlmr_hdr_ram u_hdr_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   vlmr_pkg::fsm_type state_ff, state_in;
   logic [1:0]        action_ff;
   logic [31:0]       id_ff;
   logic [15:0]       pay_ff;
   logic [AW-1:0]     read_line_ff, read_line_in;
   logic [AW-1:0]     write_line_ff, write_line_in;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [9:0]  rsp_offset_ff, rsp_offset_in;
   logic [31:0] rsp_id_ff, rsp_id_in;
   logic [15:0] rsp_size_ff, rsp_size_in;
   logic [16:0] rsp_free_ff;

   logic accept, out_free, commit;

   assign req_bus.ready = (state_ff == vlmr_pkg::FSM_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // ---- write placement ----
   logic [SW-1:0] n_w, r_w, w_w, t_w, start_w, nw_w;
   logic          bad_size, wrap, fits;

   always_comb begin
      n_w = SW'(cfg.lines);
      r_w = SW'(read_line_ff);
      w_w = SW'(write_line_ff);
      t_w = lines_for(pay_ff);
      bad_size = (17'(pay_ff) + 17'(vlmr_pkg::HEADER_BYTES))
                 > (17'(cfg.lines) << vlmr_pkg::LINE_SHIFT);
      wrap = 1'b0;
      if (w_w < r_w) begin
         fits = (r_w - w_w) >= (t_w + SW'(1));
      end else if ((n_w - w_w) < t_w) begin
         wrap = 1'b1;
         fits = r_w >= (t_w + SW'(1));
      end else begin
         // exact fit onto an empty-looking ring is refused
         fits = !(((w_w + t_w) == n_w) && (read_line_ff == '0));
      end
      start_w = wrap ? '0 : w_w;
      nw_w    = start_w + t_w;
      if (nw_w >= n_w) begin
         nw_w = '0;
      end
   end

   // ---- head message ----
   logic [AW-1:0] head_line;
   logic [SW-1:0] next_read;

   always_comb begin
      head_line = (state_ff == vlmr_pkg::FSM_ZERO) ? '0 : read_line_ff;
      next_read = SW'(head_line) + lines_for(mem_rdata[47:32]);
      if (next_read >= SW'(cfg.lines)) begin
         next_read = '0;
      end
   end

   // ---- control ----
   always_comb begin
      state_in      = state_ff;
      mem_we        = 1'b0;
      mem_waddr     = AW'(start_w);
      mem_wdata     = {1'b0, pay_ff, id_ff};
      mem_re        = 1'b0;
      mem_raddr     = read_line_ff;
      commit        = 1'b0;
      read_line_in  = read_line_ff;
      write_line_in = write_line_ff;
      rsp_status_in = vlmr_pkg::STS_OK;
      rsp_offset_in = '0;
      rsp_id_in     = '0;
      rsp_size_in   = '0;

      case (state_ff)
         vlmr_pkg::FSM_IDLE: begin
            if (accept) begin
               mem_re   = 1'b1;
               state_in = vlmr_pkg::FSM_EXEC;
            end
         end

         vlmr_pkg::FSM_EXEC: begin
            case (action_ff)
               vlmr_pkg::ACT_WRITE: begin
                  if (id_ff == '0) begin
                     rsp_status_in = vlmr_pkg::STS_BAD_ID;
                     commit        = out_free;
                  end else if (bad_size) begin
                     rsp_status_in = vlmr_pkg::STS_BAD_SIZE;
                     commit        = out_free;
                  end else if (!fits) begin
                     rsp_status_in = vlmr_pkg::STS_NO_ROOM;
                     commit        = out_free;
                  end else if (wrap) begin
                     // padding mark at the old write line, header at line 0 next
                     mem_we    = 1'b1;
                     mem_waddr = write_line_ff;
                     mem_wdata = {1'b1, 48'd0};
                     state_in  = vlmr_pkg::FSM_PAD;
                  end else begin
                     commit        = out_free;
                     mem_we        = out_free;
                     write_line_in = AW'(nw_w);
                     rsp_offset_in = 10'(start_w);
                  end
               end

               vlmr_pkg::ACT_PEEK, vlmr_pkg::ACT_CONSUME: begin
                  if (read_line_ff == write_line_ff) begin
                     rsp_status_in = vlmr_pkg::STS_EMPTY;
                     commit        = out_free;
                  end else if (mem_rdata[vlmr_pkg::PAD_BIT]) begin
                     if (write_line_ff == '0) begin
                        rsp_status_in = vlmr_pkg::STS_EMPTY;
                        commit        = out_free;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        state_in  = vlmr_pkg::FSM_ZERO;
                     end
                  end else begin
                     commit        = out_free;
                     rsp_offset_in = 10'(head_line);
                     rsp_id_in     = mem_rdata[31:0];
                     rsp_size_in   = mem_rdata[47:32];
                     if (action_ff == vlmr_pkg::ACT_CONSUME) begin
                        read_line_in = AW'(next_read);
                     end
                  end
               end

               default: begin
                  commit = out_free;
               end
            endcase
         end

         vlmr_pkg::FSM_PAD: begin
            commit        = out_free;
            mem_we        = out_free;
            write_line_in = AW'(nw_w);
            rsp_offset_in = 10'(start_w);
         end

         vlmr_pkg::FSM_ZERO: begin
            commit        = out_free;
            rsp_offset_in = 10'(head_line);
            rsp_id_in     = mem_rdata[31:0];
            rsp_size_in   = mem_rdata[47:32];
            if (action_ff == vlmr_pkg::ACT_CONSUME) begin
               read_line_in = AW'(next_read);
            end
         end

         default: begin
            state_in = vlmr_pkg::FSM_IDLE;
         end
      endcase

      if (commit) begin
         state_in = vlmr_pkg::FSM_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vlmr_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_bus.action;
         id_ff     <= req_bus.msg_id_in;
         pay_ff    <= req_bus.payload_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_line_ff  <= '0;
         write_line_ff <= '0;
      end else if (cfg.clear) begin
         read_line_ff  <= '0;
         write_line_ff <= '0;
      end else if (commit) begin
         read_line_ff  <= read_line_in;
         write_line_ff <= write_line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_size_ff   <= rsp_size_in;
         rsp_free_ff   <= free_span(cfg.lines, read_line_in, write_line_in);
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.line_offset  = rsp_offset_ff;
   assign rsp_bus.msg_id_out   = rsp_id_ff;
   assign rsp_bus.msg_size_out = rsp_size_ff;
   assign rsp_bus.free_bytes   = rsp_free_ff;

   // ---- checks ----
   a_lines_in_ring: assert property (@(posedge clock) disable iff (reset)
      (LW'(read_line_ff) < cfg.lines) && (LW'(write_line_ff) < cfg.lines))
      else $error("ring offsets outside the ring");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      !((state_ff == vlmr_pkg::FSM_IDLE) && mem_we))
      else $error("header store written with no request in flight");

   a_commit_to_idle: assert property (@(posedge clock) disable iff (reset)
      commit |=> (state_ff == vlmr_pkg::FSM_IDLE))
      else $error("control did not return to idle after a response");

   a_offsets_hold: assert property (@(posedge clock) disable iff (reset)
      (!commit && !cfg.clear) |=> ($stable(read_line_ff) && $stable(write_line_ff)))
      else $error("ring offsets moved without a commit");

endmodule

FILE: tb/variable_length_message_ring_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_length_message_ring_core_test
// Self-checking bench for the message ring space manager.
// ----------------------------------------------------------------------------
// A line-accurate model of the ring (head, tail, header store) predicts one
// response per accepted request, and responses are checked field by field in
// order. A short directed run covers the error codes, the exact-fit refusal,
// a wrap with padding and a head that runs past the ring end. Random traffic
// then runs under several ring_lines settings, clamped values included, with
// alternating fill and drain bias and random gaps on both channels.
// ----------------------------------------------------------------------------
module variable_length_message_ring_core_test;

   localparam logic [1:0] ACT_SPARE       = 2'd3;   // unused action code
   localparam logic [2:0] RING_LINES_ADDR = 3'd0;
   localparam int         WATCHDOG_LIMIT  = 2000;
   localparam int         RANDOM_PER_PHASE = 148;
   localparam int         PHASES = 9;
   localparam logic [10:0] PHASE_LINES [PHASES] = '{11'd1024, 11'd2, 11'd7, 11'd0,
                                                    11'd40, 11'd2047, 11'd1, 11'd150,
                                                    11'd1000};

   typedef struct packed {
      vlmr_pkg::status_type status;
      logic [9:0]           line_offset;
      logic [31:0]          msg_id;
      logic [15:0]          msg_size;
      logic [16:0]          free_bytes;
   } ring_reply;

   class ring_tracker;
      logic [10:0]                  ring_lines_cfg;
      int unsigned                  head_line;
      int unsigned                  tail_line;
      logic [vlmr_pkg::ENTRY_W-1:0] headers [vlmr_pkg::RING_DEPTH];
      ring_reply                    expected_replies [$];
      int unsigned                  mismatches, checked, requests, placed, wraps, skips;

      function new();
         ring_lines_cfg = 11'd1024;
         head_line = 0;
         tail_line = 0;
         foreach (headers[i]) headers[i] = '0;
      endfunction

      function void set_lines(logic [10:0] value);
         ring_lines_cfg = value;
         head_line = 0;
         tail_line = 0;
      endfunction

      function int unsigned lines_in_use();
         int unsigned v;
         v = ring_lines_cfg;
         if (v < 2) v = 2;
         if (v > vlmr_pkg::RING_DEPTH) v = vlmr_pkg::RING_DEPTH;
         return v;
      endfunction

      function int unsigned lines_needed(int unsigned pay);
         return (vlmr_pkg::HEADER_BYTES + pay + vlmr_pkg::LINE_BYTES - 1)
                / vlmr_pkg::LINE_BYTES;
      endfunction

      function void predict(logic [1:0] act, logic [31:0] id, logic [15:0] pay);
         ring_reply                    want;
         int unsigned                  n, r, w, t, start, nw, h, nr, span;
         bit                           ok, pad;
         logic [vlmr_pkg::ENTRY_W-1:0] e;
         want = '0;
         want.status = vlmr_pkg::STS_OK;
         n = lines_in_use();
         r = head_line;
         w = tail_line;
         requests++;
         if (act == vlmr_pkg::ACT_WRITE) begin
            if (id == 0) begin
               want.status = vlmr_pkg::STS_BAD_ID;
            end else if (int'(pay) + vlmr_pkg::HEADER_BYTES > n * vlmr_pkg::LINE_BYTES) begin
               want.status = vlmr_pkg::STS_BAD_SIZE;
            end else begin
               t = lines_needed(pay);
               start = w;
               pad = 1'b0;
               if (w < r) begin
                  ok = (r - w) >= t + 1;
               end else if (n - w < t) begin
                  // tail does not fit: padding header, restart at line 0
                  ok = r >= t + 1;
                  pad = 1'b1;
                  start = 0;
               end else begin
                  // exact fit to the end with head at 0 would look empty
                  ok = !((w + t == n) && (r == 0));
               end
               if (ok) begin
                  if (pad) begin
                     headers[w] = '0;
                     headers[w][vlmr_pkg::PAD_BIT] = 1'b1;
                     wraps++;
                  end
                  headers[start] = {1'b0, pay, id};
                  nw = start + t;
                  if (nw >= n) nw = 0;
                  tail_line = nw;
                  want.line_offset = 10'(start);
                  placed++;
               end else begin
                  want.status = vlmr_pkg::STS_NO_ROOM;
               end
            end
         end else if (act == vlmr_pkg::ACT_PEEK || act == vlmr_pkg::ACT_CONSUME) begin
            if (r == w) begin
               want.status = vlmr_pkg::STS_EMPTY;
            end else begin
               h = r;
               e = headers[h];
               if (e[vlmr_pkg::PAD_BIT]) begin
                  h = 0;
                  skips++;
                  if (w == 0) want.status = vlmr_pkg::STS_EMPTY;
                  else e = headers[0];
               end
               if (want.status == vlmr_pkg::STS_OK) begin
                  want.line_offset = 10'(h);
                  want.msg_id = e[31:0];
                  want.msg_size = e[47:32];
                  if (act == vlmr_pkg::ACT_CONSUME) begin
                     nr = h + lines_needed(e[47:32]);
                     if (nr >= n) nr = 0;
                     head_line = nr;
                  end
               end
            end
         end
         if (tail_line >= head_line) begin
            span = n - tail_line;
            if (head_line > span) span = head_line;
         end else begin
            span = head_line - tail_line;
         end
         want.free_bytes = 17'(span * vlmr_pkg::LINE_BYTES);
         expected_replies.push_back(want);
      endfunction

      function void compare_field(string what, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
            mismatches++;
         end
      endfunction

      function void check_reply(ring_reply got);
         ring_reply want;
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected response: expected none, got status %0d offset %0d",
                     $time, got.status, got.line_offset);
            mismatches++;
            return;
         end
         want = expected_replies.pop_front();
         checked++;
         compare_field("status", want.status, got.status);
         compare_field("line_offset", want.line_offset, got.line_offset);
         compare_field("msg_id_out", want.msg_id, got.msg_id);
         compare_field("msg_size_out", want.msg_size, got.msg_size);
         compare_field("free_bytes", want.free_bytes, got.free_bytes);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;
   bit          idle_on = 1'b1;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;
   ring_tracker book = new();

   vlmr_req_if req ();
   vlmr_rsp_if rsp ();

   variable_length_message_ring_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #2 clock = ~clock;

   // response side back-pressure in bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      ring_reply got;
      if (!reset) begin
         if ((req.valid === 1'b1 && req.ready === 1'b1) ||
             (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            got.status = vlmr_pkg::status_type'(rsp.status);
            got.line_offset = rsp.line_offset;
            got.msg_id = rsp.msg_id_out;
            got.msg_size = rsp.msg_size_out;
            got.free_bytes = rsp.free_bytes;
            book.check_reply(got);
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic push_request(input logic [1:0] act, input logic [31:0] id,
                               input logic [15:0] pay);
      int unsigned gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.action <= act;
      req.msg_id_in <= id;
      req.payload_bytes <= pay;
      do @(posedge clock); while (req.ready !== 1'b1);
      book.predict(act, id, pay);
   endtask

   // stop requesting and wait for every outstanding response
   task automatic await_replies();
      req.valid <= 1'b0;
      while (book.expected_replies.size() != 0) @(posedge clock);
   endtask

   task automatic program_ring_lines(input logic [10:0] value);
      await_replies();
      repeat (4) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= RING_LINES_ADDR;
      pwdata <= {21'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      book.set_lines(value);
   endtask

   function automatic logic [15:0] pick_payload(int unsigned n);
      int          p;
      int unsigned roll, cap, t;
      roll = $urandom_range(0, 99);
      cap = n / 4;
      if (cap < 1) cap = 1;
      if (roll < 70) begin
         t = $urandom_range(1, cap);
         p = int'(t) * vlmr_pkg::LINE_BYTES - vlmr_pkg::HEADER_BYTES
             - int'($urandom_range(0, 63));
      end else if (roll < 85) begin
         p = $urandom_range(0, 65535);
      end else if (roll < 95) begin
         // around the largest message the ring can take
         p = int'(n) * vlmr_pkg::LINE_BYTES - vlmr_pkg::HEADER_BYTES - 4
             + int'($urandom_range(0, 8));
      end else begin
         p = ($urandom_range(0, 1) != 0) ? 65535 : 0;
      end
      if (p < 0) p = 0;
      if (p > 65535) p = 65535;
      return p[15:0];
   endfunction

   task automatic random_phase(input int unsigned count);
      int unsigned n, k, roll;
      bit          fill;
      logic [1:0]  act;
      logic [31:0] id;
      logic [15:0] pay;
      n = book.lines_in_use();
      fill = 1'b1;
      for (k = 0; k < count; k++) begin
         if (k != 0 && k % 40 == 0) fill = ~fill;
         if (k == count / 2) await_replies();
         roll = $urandom_range(0, 99);
         if (fill) begin
            if (roll < 60) act = vlmr_pkg::ACT_WRITE;
            else if (roll < 75) act = vlmr_pkg::ACT_PEEK;
            else if (roll < 95) act = vlmr_pkg::ACT_CONSUME;
            else act = ACT_SPARE;
         end else begin
            if (roll < 20) act = vlmr_pkg::ACT_WRITE;
            else if (roll < 40) act = vlmr_pkg::ACT_PEEK;
            else if (roll < 95) act = vlmr_pkg::ACT_CONSUME;
            else act = ACT_SPARE;
         end
         id = $urandom;
         if (act == vlmr_pkg::ACT_WRITE) begin
            if ($urandom_range(0, 32) == 0) id = '0;
            pay = pick_payload(n);
         end else begin
            pay = $urandom_range(0, 65535);
         end
         push_request(act, id, pay);
      end
   endtask

   initial begin
      int p;
      req.valid <= 1'b0;
      req.action <= vlmr_pkg::ACT_WRITE;
      req.msg_id_in <= '0;
      req.payload_bytes <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed run on the reset ring of 1024 lines
      push_request(vlmr_pkg::ACT_PEEK, 32'd0, 16'd0);
      push_request(vlmr_pkg::ACT_CONSUME, 32'hFFFF_FFFF, 16'hFFFF);
      push_request(vlmr_pkg::ACT_WRITE, 32'd0, 16'd100);
      push_request(vlmr_pkg::ACT_WRITE, 32'd0, 16'd65535);          // id checked before size
      push_request(vlmr_pkg::ACT_WRITE, 32'd1, 16'd65535);
      push_request(vlmr_pkg::ACT_WRITE, 32'hFFFF_FFFF, 16'd65528);  // exact fit with head at 0
      push_request(ACT_SPARE, 32'h1234_5678, 16'hABCD);
      push_request(vlmr_pkg::ACT_WRITE, 32'hFFFF_FFFF, 16'd0);
      push_request(vlmr_pkg::ACT_WRITE, 32'h8000_0001, 16'd56);
      push_request(vlmr_pkg::ACT_WRITE, 32'h0000_0002, 16'd57);
      push_request(vlmr_pkg::ACT_PEEK, 32'd0, 16'd0);
      push_request(vlmr_pkg::ACT_CONSUME, 32'd0, 16'd0);
      push_request(vlmr_pkg::ACT_WRITE, 32'h7FFF_FFFF, 16'd40000);
      push_request(vlmr_pkg::ACT_WRITE, 32'h5555_5555, 16'd24000);
      push_request(vlmr_pkg::ACT_CONSUME, 32'd0, 16'd0);
      push_request(vlmr_pkg::ACT_CONSUME, 32'd0, 16'd0);
      push_request(vlmr_pkg::ACT_CONSUME, 32'd0, 16'd0);
      push_request(vlmr_pkg::ACT_WRITE, 32'hAAAA_AAAA, 16'd2000);   // wraps behind padding
      push_request(vlmr_pkg::ACT_CONSUME, 32'd0, 16'd0);
      push_request(vlmr_pkg::ACT_PEEK, 32'd0, 16'd0);                // skips the padding
      push_request(vlmr_pkg::ACT_CONSUME, 32'd0, 16'd0);
      push_request(vlmr_pkg::ACT_PEEK, 32'd0, 16'd0);
      push_request(vlmr_pkg::ACT_WRITE, 32'h5A5A_A5A5, 16'd63480);  // ends on the ring end
      push_request(vlmr_pkg::ACT_CONSUME, 32'd0, 16'd0);             // head runs past the end

      for (p = 0; p < PHASES; p++) begin
         program_ring_lines(PHASE_LINES[p]);
         if (p == PHASES - 1) idle_on = 1'b0;
         random_phase(RANDOM_PER_PHASE);
      end

      await_replies();
      repeat (10) @(posedge clock);
      $display("%0d requests, %0d responses checked over %0d ring_lines settings",
               book.requests, book.checked, PHASES + 1);
      $display("%0d messages placed, %0d wraps behind padding, %0d padding skips",
               book.placed, book.wraps, book.skips);
      if (book.mismatches == 0 && book.expected_replies.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/vlmr_pkg.sv
sv/vlmr_if.sv
sv/vlmr_hdr_ram.sv
sv/vlmr_csr.sv
sv/variable_length_message_ring_core.sv
tb/variable_length_message_ring_core_test.sv
